// File: hw/rtl/psgde_pkg.sv
// ----------------------------------------------------------------------------
// PSG delta encoder package
// Operation codes, stream constants and the command passed from the
// front end to the byte sequencer.
// ----------------------------------------------------------------------------
package psgde_pkg;

   localparam int NUM_REGS = 14;
   localparam int ENV_REG = 13;
   localparam bit ENV_PRESENT = (ENV_REG < NUM_REGS);
   localparam int REG_SEL_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   localparam logic [7:0] RUN_MARK = 8'hFE;
   localparam logic [7:0] ONE_FRAME = 8'hFF;
   localparam logic [7:0] ENV_IDLE_VALUE = 8'hFF;
   localparam logic [7:0] FULL_GROUPS = 8'd255;
   localparam logic [9:0] IDLE_LIMIT = 10'd1023;
   localparam logic [9:0] IDLE_AFTER_FULL = 10'd4;

   typedef struct packed {
      logic [7:0] groups;
      logic [1:0] rest;
      logic       has_reg;
      logic [3:0] reg_index;
      logic [7:0] reg_value;
   } cmd_type;

endpackage

// File: hw/rtl/psgde_if.sv
// ----------------------------------------------------------------------------
// PSG delta encoder channels
// Valid/ready channels for the input operations and the output byte stream.
// ----------------------------------------------------------------------------
interface psgde_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [3:0] reg_index;
   logic [7:0] reg_value;

   modport source (output valid, output op, output reg_index, output reg_value,
                   input ready);
   modport sink (input valid, input op, input reg_index, input reg_value,
                 output ready);
endinterface

interface psgde_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink (input valid, input out_byte, input last, output ready);
endinterface

// File: hw/rtl/psg_register_delta_encoder_core.sv
// ----------------------------------------------------------------------------
// PSG register delta encoder
// An item's bytes pass through the command queue and the registered output.
// Throughput: one item per cycle while the two-entry command queue has room;
// the output delivers one byte per cycle while the receiver is ready, and an
// item produces no bytes or up to seven, expanded by the byte sequencer.
// Reset clears the idle counter, the recorded flags, the queue and the output.
// ----------------------------------------------------------------------------
module psg_register_delta_encoder_core (
   input  logic       clock,
   input  logic       reset,
   psgde_req_if.sink  req_ch,
   psgde_rsp_if.source rsp_ch
);
   import psgde_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic front_valid;
   logic queue_not_full;
   logic queue_not_empty;
   logic queue_pop;

   psgde_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_ready (queue_not_full),
      .cmd_valid (front_valid),
      .cmd       (front_cmd)
   );

   psgde_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_cmd  (front_cmd),
      .not_full  (queue_not_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head      (head_cmd)
   );

   psgde_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (queue_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

// File: hw/rtl/psgde_front.sv
// ----------------------------------------------------------------------------
// PSG delta encoder front end
// Accepts operations, tracks recorded registers and the idle run, and
// issues byte commands to the queue.
// ----------------------------------------------------------------------------
module psgde_front (
   input  logic                 clock,
   input  logic                 reset,
   psgde_req_if.sink            req_ch,
   input  logic                 cmd_ready,
   output logic                 cmd_valid,
   output psgde_pkg::cmd_type   cmd
);
   import psgde_pkg::*;

   localparam logic [REG_SEL_W-1:0] ENV_SLOT =
      REG_SEL_W'(ENV_PRESENT ? ENV_REG : 0);

   logic [7:0] value_ff [NUM_REGS];
   logic [NUM_REGS-1:0] known_ff;
   logic [NUM_REGS-1:0] known_in;
   logic [9:0] idle_ff;
   logic [9:0] idle_in;

   logic accept;
   logic in_range;
   logic [REG_SEL_W-1:0] sel;
   logic changed;
   logic push;
   logic write_sample;
   logic write_env;

   assign req_ch.ready = cmd_ready;
   assign accept = req_ch.valid && cmd_ready;
   assign in_range = ({1'b0, req_ch.reg_index} < 5'(NUM_REGS));
   assign sel = req_ch.reg_index[REG_SEL_W-1:0];
   assign changed = in_range && (!known_ff[sel] || (value_ff[sel] != req_ch.reg_value));

   always_comb begin
      idle_in = idle_ff;
      push = 1'b0;
      write_sample = 1'b0;
      write_env = 1'b0;
      cmd.groups = idle_ff[9:2];
      cmd.rest = idle_ff[1:0];
      cmd.has_reg = 1'b0;
      cmd.reg_index = req_ch.reg_index;
      cmd.reg_value = req_ch.reg_value;
      unique case (req_ch.op)
         OP_TICK: begin
            write_env = ENV_PRESENT;
            if (idle_ff >= IDLE_LIMIT) begin
               push = 1'b1;
               cmd.groups = FULL_GROUPS;
               cmd.rest = 2'd0;
               idle_in = IDLE_AFTER_FULL;
            end else begin
               idle_in = idle_ff + 10'd1;
            end
         end
         OP_SAMPLE: begin
            if (changed) begin
               push = 1'b1;
               write_sample = 1'b1;
               cmd.has_reg = 1'b1;
               idle_in = 10'd0;
            end
         end
         OP_FLUSH: begin
            push = (idle_ff != 10'd0);
            idle_in = 10'd0;
         end
         default: begin
         end
      endcase
   end

   assign cmd_valid = accept && push;

   always_comb begin
      known_in = known_ff;
      if (accept && write_sample) begin
         known_in[sel] = 1'b1;
      end
      if (accept && write_env) begin
         known_in[ENV_SLOT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
         idle_ff <= '0;
      end else begin
         known_ff <= known_in;
         if (accept) begin
            idle_ff <= idle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && write_sample) begin
         value_ff[sel] <= req_ch.reg_value;
      end
      if (accept && write_env) begin
         value_ff[ENV_SLOT] <= ENV_IDLE_VALUE;
      end
   end

endmodule

// File: hw/rtl/psgde_cmd_queue.sv
// ----------------------------------------------------------------------------
// PSG delta encoder command queue
// Two-entry queue that decouples the front end from the byte sequencer.
// ----------------------------------------------------------------------------
module psgde_cmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  psgde_pkg::cmd_type   push_cmd,
   output logic                 not_full,
   input  logic                 pop,
   output logic                 not_empty,
   output psgde_pkg::cmd_type   head
);
   import psgde_pkg::*;

   cmd_type slot_ff [2];
   logic wr_ptr_ff;
   logic wr_ptr_in;
   logic rd_ptr_ff;
   logic rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign not_full = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hw/rtl/psgde_back.sv
// ----------------------------------------------------------------------------
// PSG delta encoder byte sequencer
// Expands each queued command into run bytes and, if it carries one, a
// register write, one byte per cycle into a registered output unless stalled.
// ----------------------------------------------------------------------------
module psgde_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  psgde_pkg::cmd_type   cmd,
   output logic                 cmd_pop,
   psgde_rsp_if.source          rsp_ch
);
   import psgde_pkg::*;

   localparam logic [2:0] P_START = 3'd0;
   localparam logic [2:0] P_MARK = 3'd1;
   localparam logic [2:0] P_COUNT = 3'd2;
   localparam logic [2:0] P_ONE = 3'd3;
   localparam logic [2:0] P_IDX = 3'd4;
   localparam logic [2:0] P_VAL = 3'd5;

   logic [2:0] phase_ff;
   logic [2:0] phase_in;
   logic [1:0] left_ff;
   logic [1:0] left_in;
   logic valid_ff;
   logic valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic last_ff;
   logic last_in;

   logic [2:0] cur_phase;
   logic [2:0] next_phase;
   logic [2:0] after_run;
   logic [1:0] cur_left;
   logic fire;

   assign fire = cmd_valid && (!valid_ff || rsp_ch.ready);
   assign after_run = cmd.has_reg ? P_IDX : P_START;
   assign cur_left = (phase_ff == P_ONE) ? left_ff : cmd.rest;

   always_comb begin
      if (phase_ff != P_START) begin
         cur_phase = phase_ff;
      end else if (cmd.groups != 8'd0) begin
         cur_phase = P_MARK;
      end else if (cmd.rest != 2'd0) begin
         cur_phase = P_ONE;
      end else begin
         cur_phase = P_IDX;
      end
   end

   always_comb begin
      byte_in = 8'd0;
      next_phase = P_START;
      left_in = left_ff;
      unique case (cur_phase)
         P_MARK: begin
            byte_in = RUN_MARK;
            next_phase = P_COUNT;
         end
         P_COUNT: begin
            byte_in = cmd.groups;
            left_in = cmd.rest;
            next_phase = (cmd.rest != 2'd0) ? P_ONE : after_run;
         end
         P_ONE: begin
            byte_in = ONE_FRAME;
            left_in = cur_left - 2'd1;
            next_phase = (cur_left > 2'd1) ? P_ONE : after_run;
         end
         P_IDX: begin
            byte_in = 8'(cmd.reg_index);
            next_phase = P_VAL;
         end
         P_VAL: begin
            byte_in = cmd.reg_value;
            next_phase = P_START;
         end
         default: begin
         end
      endcase
   end

   assign last_in = (next_phase == P_START);
   assign cmd_pop = fire && last_in;
   assign phase_in = fire ? next_phase : phase_ff;
   assign valid_in = fire || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_START;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         left_ff <= left_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.out_byte = byte_ff;
   assign rsp_ch.last = last_ff;

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (rsp_ch.valid && rsp_ch.last))
      else $error("Command retired without a final byte.");

   a_mid_command_head: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != P_START) |-> cmd_valid)
      else $error("Queue head lost in the middle of a command.");

   a_one_frame_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == P_ONE) |-> (left_ff != 2'd0))
      else $error("Idle frame bytes continue past the leftover count.");

endmodule
